@@ design/bcn_texture_block_decoder_macros.svh @@
// Assertion macros shared by the block decoder
`ifndef BCN_TEXTURE_BLOCK_DECODER_MACROS_SVH
`define BCN_TEXTURE_BLOCK_DECODER_MACROS_SVH

`ifndef SYNTH
`define BTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BTD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BTD_ASSERT(label, prop, msg)
`define BTD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ design/btd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package btd_pkg;

    localparam int unsigned PIXELS    = 16;
    localparam int unsigned PIX_W     = $clog2(PIXELS);
    localparam int unsigned CFG_W     = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 1'd1;

    typedef enum logic [CFG_W-1:0] {
        FMT_BC1 = 3'd0,
        FMT_BC2 = 3'd1,
        FMT_BC3 = 3'd2,
        FMT_BC4 = 3'd3,
        FMT_BC5 = 3'd4
    } t_fmt;

    localparam logic [CFG_W-1:0] PB_RESET = 3'd4;

    localparam logic [3:0] MASK_NONE = 4'h0;
    localparam logic [3:0] MASK_R    = 4'h1;
    localparam logic [3:0] MASK_G    = 4'h2;
    localparam logic [3:0] MASK_RGB  = 4'h7;
    localparam logic [3:0] MASK_RGBA = 4'hF;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_blk_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [3:0]       write_mask;
        logic             last;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        widen6 = {v, v[5:4]};
    endfunction

    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        avg8 = s[8:1];
    endfunction

    // Color palette lookup for pixel k of a 64-bit color word
    function automatic t_rgba colour_pixel(input logic [63:0] w, input logic [PIX_W-1:0] k);
        logic [7:0] ar, ag, ab, br, bg, bb;
        logic [1:0] idx;
        t_rgba      c;
        ar  = widen5(w[15:11]);
        ag  = widen6(w[10:5]);
        ab  = widen5(w[4:0]);
        br  = widen5(w[31:27]);
        bg  = widen6(w[26:21]);
        bb  = widen5(w[20:16]);
        idx = w[32 + 2 * k +: 2];
        unique case (idx)
            2'd0: begin
                c = '{r: ar, g: ag, b: ab, a: 8'hFF};
            end
            2'd1: begin
                c = '{r: br, g: bg, b: bb, a: 8'hFF};
            end
            default: begin
                c = '{r: avg8(ar, br), g: avg8(ag, bg), b: avg8(ab, bb), a: 8'hFF};
            end
        endcase
        if (idx == 2'd3) begin
            c.a = 8'h00;
        end
        colour_pixel = c;
    endfunction

    function automatic logic [7:0] single_pixel(input logic [63:0] w,
                                                input logic [PIX_W-1:0] k);
        logic [2:0] idx;
        logic [7:0] v;
        idx = w[16 + 3 * k +: 3];
        unique case (idx)
            3'd0:    v = w[7:0];
            3'd1:    v = w[15:8];
            3'd6:    v = 8'h00;
            3'd7:    v = 8'hFF;
            default: v = avg8(w[7:0], w[15:8]);
        endcase
        single_pixel = v;
    endfunction

    function automatic logic [7:0] explicit_alpha(input logic [63:0] w,
                                                  input logic [PIX_W-1:0] k);
        logic [3:0] n;
        n = w[4 * k +: 4];
        explicit_alpha = {n, n};
    endfunction

endpackage

`default_nettype wire

@@ design/bcn_texture_block_decoder.sv @@
// Channel   Ports                                 Direction  Handshake
// request   i_block (block_low, block_high)       in         start & !busy
// result    o_result (pixel, channels, mask)      out        o_strobe, one cycle
// config    i_cfg_we, i_cfg_idx, i_cfg_data       in         i_cfg_we
//
// Each block gives sixteen pixels, one per cycle, in row-major order.
// Once its request is taken, the first pixel reaches o_result through the pixel counter and
// then the result register; the pixel counter (one palette decode per cycle) steps through all sixteen pixels.
// busy drops on the cycle that decodes pixel fifteen, so blocks stream gap-free.
// Reset is synchronous, active low: format BC1, four bytes per pixel, no block.
// The receiver cannot stall; every result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "bcn_texture_block_decoder_macros.svh"

module bcn_texture_block_decoder
    import btd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_blk_in              i_block,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_strobe,
    output t_pix_out                  o_result
);

    logic [CFG_W-1:0] r_fmt, r_pb;
    t_blk_in          r_blk, n_blk;
    logic [PIX_W-1:0] r_cnt, n_cnt;
    logic             r_act, n_act;
    logic             r_strobe, n_strobe;
    t_pix_out         r_res, n_res;

    logic             accept;
    logic             on_last;
    logic             pb_ok;
    logic [63:0]      colour_word;
    t_rgba            c;

    assign on_last = (r_cnt == PIX_W'(PIXELS - 1));
    assign busy    = r_act && !on_last;
    assign accept  = start && !busy;

    always_comb begin
        n_blk    = r_blk;
        n_cnt    = r_cnt;
        n_act    = r_act;
        n_strobe = r_act;
        if (r_act) begin
            n_cnt = r_cnt + PIX_W'(1);
            if (on_last) begin
                n_act = 1'b0;
            end
        end
        if (accept) begin
            n_blk = i_block;
            n_cnt = '0;
            n_act = 1'b1;
        end
    end

    // decode pixel r_cnt of the held block
    assign pb_ok       = (r_pb >= 3'd1) && (r_pb <= 3'd4);
    assign colour_word = (r_fmt == FMT_BC1) ? r_blk.block_low : r_blk.block_high;
    assign c           = colour_pixel(colour_word, r_cnt);

    always_comb begin
        n_res             = '0;
        n_res.pixel_index = r_cnt;
        n_res.last        = on_last;
        unique case (r_fmt)
            FMT_BC1, FMT_BC2, FMT_BC3: begin
                if (r_pb == 3'd4) begin
                    n_res.red        = c.r;
                    n_res.green      = c.g;
                    n_res.blue       = c.b;
                    n_res.write_mask = MASK_RGBA;
                    if (r_fmt == FMT_BC2) begin
                        n_res.alpha = explicit_alpha(r_blk.block_low, r_cnt);
                    end else if (r_fmt == FMT_BC3) begin
                        n_res.alpha = single_pixel(r_blk.block_low, r_cnt);
                    end else begin
                        n_res.alpha = c.a;
                    end
                end else if (r_pb == 3'd3) begin
                    n_res.red        = c.r;
                    n_res.green      = c.g;
                    n_res.blue       = c.b;
                    n_res.write_mask = MASK_RGB;
                end
            end
            FMT_BC4: begin
                if (pb_ok) begin
                    n_res.red        = single_pixel(r_blk.block_low, r_cnt);
                    n_res.write_mask = MASK_R;
                end
            end
            FMT_BC5: begin
                if (pb_ok) begin
                    n_res.red        = single_pixel(r_blk.block_low, r_cnt);
                    n_res.write_mask = MASK_R;
                end
                if (pb_ok && r_pb >= 3'd2) begin
                    n_res.green      = single_pixel(r_blk.block_high, r_cnt);
                    n_res.write_mask = MASK_R | MASK_G;
                end
            end
            default: begin
                n_res.write_mask = MASK_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_BC1;
            r_pb     <= PB_RESET;
            r_cnt    <= '0;
            r_act    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_BLOCK_FORMAT) begin
                r_fmt <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_PIXEL_BYTES) begin
                r_pb <= i_cfg_data;
            end
            r_cnt    <= n_cnt;
            r_act    <= n_act;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `BTD_ASSERT(a_run_contiguous,
        o_strobe && !o_result.last |=> o_strobe, "pixel burst broken")
    `BTD_ASSERT(a_index_steps,
        o_strobe && !o_result.last |=>
            (o_result.pixel_index == $past(o_result.pixel_index) + PIX_W'(1)),
        "pixel index skipped")
    `BTD_ASSERT(a_last_flag,
        o_strobe |-> (o_result.last == (o_result.pixel_index == PIX_W'(PIXELS - 1))),
        "last flag off pixel fifteen")
    `BTD_ASSERT(a_accept_to_first,
        accept |=> ##1 (o_strobe && o_result.pixel_index == '0),
        "first pixel missing after request")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import btd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start      = 1'b0;
    logic                 busy;
    t_blk_in              i_block    = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = REG_BLOCK_FORMAT;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_strobe;
    t_pix_out             o_result;

    // shadow of the block's registers, changed only while the block is idle
    logic [CFG_W-1:0] fmt_cfg = FMT_BC1;
    logic [CFG_W-1:0] pb_cfg  = PB_RESET;

    t_blk_in     block_q[$];
    t_pix_out    pixel_q[$];
    int unsigned idle_cnt   = 0;
    bit          no_gaps    = 1'b0;
    int unsigned errors     = 0;
    int unsigned cycles     = 0;

    bcn_texture_block_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_block    (i_block),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        fork
            forever #1 i_clk = ~i_clk;
            begin
                repeat (3) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
        join_none
    end

    // Widen an n-bit endpoint channel to 8 bits by repeating its top bits.
    function automatic int unsigned replicate(input int unsigned v, input int unsigned bits);
        return ((v << (8 - bits)) | (v >> (2 * bits - 8))) & 255;
    endfunction

    // One entry of the eight-way single-channel palette.
    function automatic int unsigned channel_value(input logic [63:0] w, input int unsigned k);
        int unsigned lo_v, hi_v, sel;
        lo_v = 32'(w[7:0]);
        hi_v = 32'(w[15:8]);
        sel  = 32'((w >> (16 + 3 * k)) & 64'd7);
        case (sel)
            0:       return lo_v;
            1:       return hi_v;
            6:       return 0;
            7:       return 255;
            default: return (lo_v + hi_v) / 2;
        endcase
    endfunction

    // Decode one block into its sixteen pixels under the current register values.
    task automatic predict_block(input t_blk_in blk);
        t_pix_out    px;
        logic [63:0] cw;
        int unsigned ea, eb, sel, k, c;
        int unsigned end_a[3], end_b[3], rgb[3], alpha;
        bit          pb_valid;
        cw       = (fmt_cfg == FMT_BC1) ? blk.block_low : blk.block_high;
        ea       = 32'(cw[15:0]);
        eb       = 32'(cw[31:16]);
        end_a[0] = replicate((ea >> 11) & 31, 5);
        end_a[1] = replicate((ea >> 5) & 63, 6);
        end_a[2] = replicate(ea & 31, 5);
        end_b[0] = replicate((eb >> 11) & 31, 5);
        end_b[1] = replicate((eb >> 5) & 63, 6);
        end_b[2] = replicate(eb & 31, 5);
        pb_valid = (pb_cfg >= 1) && (pb_cfg <= 4);
        for (k = 0; k < PIXELS; k++) begin
            px  = '0;
            sel = 32'((cw >> (32 + 2 * k)) & 64'd3);
            for (c = 0; c < 3; c++) begin
                if (sel == 0) rgb[c] = end_a[c];
                else if (sel == 1) rgb[c] = end_b[c];
                else rgb[c] = (end_a[c] + end_b[c]) / 2;
            end
            alpha = (sel == 3) ? 0 : 255;
            case (fmt_cfg)
                FMT_BC1, FMT_BC2, FMT_BC3: begin
                    if (pb_cfg == 4 || pb_cfg == 3) begin
                        px.red        = 8'(rgb[0]);
                        px.green      = 8'(rgb[1]);
                        px.blue       = 8'(rgb[2]);
                        px.write_mask = MASK_RGB;
                    end
                    if (pb_cfg == 4) begin
                        // alpha from the low half replaces the palette alpha
                        if (fmt_cfg == FMT_BC2)
                            alpha = 32'((blk.block_low >> (4 * k)) & 64'd15) * 17;
                        else if (fmt_cfg == FMT_BC3)
                            alpha = channel_value(blk.block_low, k);
                        px.alpha      = 8'(alpha);
                        px.write_mask = MASK_RGBA;
                    end
                end
                FMT_BC4: begin
                    if (pb_valid) begin
                        px.red        = 8'(channel_value(blk.block_low, k));
                        px.write_mask = MASK_R;
                    end
                end
                FMT_BC5: begin
                    if (pb_valid) begin
                        px.red        = 8'(channel_value(blk.block_low, k));
                        px.write_mask = MASK_R;
                    end
                    if (pb_valid && pb_cfg >= 2) begin
                        px.green      = 8'(channel_value(blk.block_high, k));
                        px.write_mask = px.write_mask | MASK_G;
                    end
                end
                default: begin
                end
            endcase
            px.pixel_index = PIX_W'(k);
            px.last        = (k == PIXELS - 1);
            pixel_q.push_back(px);
        end
    endtask

    // Request driver: hold start until taken, then idle for a drawn number of cycles.
    always @(posedge i_clk) begin
        logic start_n;
        if (!i_rst_n) begin
            start    <= 1'b0;
            idle_cnt = 0;
        end else begin
            start_n = start;
            if (start && !busy) begin
                predict_block(i_block);
                start_n  = 1'b0;
                idle_cnt = no_gaps ? 0 : $urandom_range(0, 7);
            end
            if (!start_n) begin
                if (idle_cnt > 0) begin
                    idle_cnt--;
                end else if (block_q.size() != 0) begin
                    start_n = 1'b1;
                    i_block <= block_q.pop_front();
                end
            end
            start <= start_n;
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_strobe) begin
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t: pixel with none expected, expected none, actual %h",
                         $time, o_result);
            end else begin
                want = pixel_q.pop_front();
                check_field("pixel_index", 32'(want.pixel_index),
                            32'(o_result.pixel_index));
                check_field("red", 32'(want.red), 32'(o_result.red));
                check_field("green", 32'(want.green), 32'(o_result.green));
                check_field("blue", 32'(want.blue), 32'(o_result.blue));
                check_field("alpha", 32'(want.alpha), 32'(o_result.alpha));
                check_field("write_mask", 32'(want.write_mask),
                            32'(o_result.write_mask));
                check_field("last", 32'(want.last), 32'(o_result.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic set_config(input logic [CFG_W-1:0] fmt, input logic [CFG_W-1:0] pb);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_BLOCK_FORMAT;
        i_cfg_data <= fmt;
        @(posedge i_clk);
        i_cfg_idx  <= REG_PIXEL_BYTES;
        i_cfg_data <= pb;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        fmt_cfg = fmt;
        pb_cfg  = pb;
        @(negedge i_clk);
    endtask

    // Wait for every queued request to be taken and every pixel to arrive.
    task automatic drain();
        while (block_q.size() != 0 || start || pixel_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        t_blk_in          directed[6];
        t_blk_in          blk;
        logic [CFG_W-1:0] dir_fmt[4];
        logic [CFG_W-1:0] dir_pb[4];
        logic [CFG_W-1:0] rnd_fmt[20];
        logic [CFG_W-1:0] rnd_pb[20];
        int               s, n;

        // palette ramps: color index k%4, single-channel index k%8 and 7-k%8
        directed[0] = '{block_high: 64'h0, block_low: 64'h0};
        directed[1] = '{block_high: '1, block_low: '1};
        directed[2] = '{block_high: {48'hFAC688FAC688, 8'hFF, 8'h00},
                        block_low:  {32'hE4E4E4E4, 16'h0000, 16'hFFFF}};
        directed[3] = '{block_high: {32'hE4E4E4E4, 16'h7BEF, 16'h8410},
                        block_low:  {48'hFAC688FAC688, 8'hFF, 8'hFF}};
        directed[4] = '{block_high: {32'hE4E4E4E4, 16'hFFFF, 16'h0000},
                        block_low:  64'hFEDCBA9876543210};
        directed[5] = '{block_high: {48'h053977053977, 8'h80, 8'h7F},
                        block_low:  {48'hFAC688FAC688, 8'h00, 8'h01}};

        dir_fmt = '{FMT_BC1, FMT_BC2, FMT_BC3, FMT_BC5};
        dir_pb  = '{3'd4, 3'd4, 3'd4, 3'd2};
        rnd_fmt = '{FMT_BC1, FMT_BC2, FMT_BC3, FMT_BC4, FMT_BC4, FMT_BC5, FMT_BC5,
                    FMT_BC5, FMT_BC1, FMT_BC2, FMT_BC3, FMT_BC1, 3'd5, 3'd6, 3'd7,
                    FMT_BC4, FMT_BC5, FMT_BC1, FMT_BC2, FMT_BC3};
        rnd_pb  = '{3'd3, 3'd3, 3'd3, 3'd1, 3'd4, 3'd1, 3'd3, 3'd4, 3'd1, 3'd2,
                    3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4};

        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // first set runs on the reset register values
        for (s = 0; s < 4; s++) begin
            if (s != 0) set_config(dir_fmt[s], dir_pb[s]);
            no_gaps = (s == 2);
            foreach (directed[d]) block_q.push_back(directed[d]);
            drain();
        end

        for (s = 0; s < 20; s++) begin
            set_config(rnd_fmt[s], rnd_pb[s]);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 15; n++) begin
                blk.block_low  = {$urandom, $urandom};
                blk.block_high = {$urandom, $urandom};
                // bias some blocks toward equal endpoints and saturated values
                case ($urandom_range(0, 7))
                    0: blk.block_low[31:16] = blk.block_low[15:0];
                    1: blk.block_high[31:16] = blk.block_high[15:0];
                    2: blk.block_low[15:8] = blk.block_low[7:0];
                    3: blk.block_high[15:0] = 16'hFFFF;
                    default: begin
                    end
                endcase
                block_q.push_back(blk);
            end
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
